@@ hw/rtl/ucdc_pkg.sv @@
// Shared types, codes and CRC helper for the UART register datagram codec.
`default_nettype none

package ucdc_pkg;

  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] WRITE_FLAG  = 8'h80;
  localparam logic [7:0] MASTER_ADDR = 8'hFF;
  localparam logic [7:0] SYNC_RESET  = 8'h05;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // input item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;

  // configuration register indexes
  localparam logic CFG_NODE_ADDRESS = 1'b0;
  localparam logic CFG_SYNC_BYTE    = 1'b1;

  // reply status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SYNC = 3'd1;
  localparam logic [2:0] ST_BAD_ADDR = 3'd2;
  localparam logic [2:0] ST_BAD_REG  = 3'd3;
  localparam logic [2:0] ST_BAD_CRC  = 3'd4;

  // byte positions inside a datagram
  localparam logic [2:0] POS_SYNC      = 3'd0;
  localparam logic [2:0] POS_ADDR      = 3'd1;
  localparam logic [2:0] POS_REG       = 3'd2;
  localparam logic [2:0] POS_READ_CRC  = 3'd3;
  localparam logic [2:0] POS_WRITE_CRC = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  reg_address;
    logic [31:0] write_value;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        reply_valid;
    logic [2:0]  reply_status;
    logic [31:0] reply_data;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_WRITE,
    JOB_READ,
    JOB_REPLY
  } job_op_t;

  // one queued job: a request to frame, or a checked reply to report
  typedef struct packed {
    job_op_t     op;
    logic [6:0]  reg_address;
    logic [31:0] value;
    logic [2:0]  status;
  } job_t;

  typedef struct packed {
    logic [7:0] node_address;
    logic [7:0] sync_byte;
  } cfg_t;

  // one byte of CRC-8, data LSB first, CRC shifted from its top bit
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in;
    for (int j = 0; j < 8; j++) begin
      if (c[7] ^ data[j]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ucdc_front.sv @@
// Front end: accepts items, turns commands into jobs and checks reply bytes.
`default_nettype none

module ucdc_front
  import ucdc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     accept,
  input  wire in_item_t item,
  output logic          push,
  output job_t          push_job
);

  logic [2:0]  reply_count;
  logic [6:0]  expected_register;
  logic [7:0]  rx_crc;
  logic [2:0]  rx_status;
  logic [31:0] rx_data;
  logic [7:0]  rx_first;

  logic [7:0]  crc_base;
  logic [7:0]  crc_next;
  logic [2:0]  status_next;
  logic [2:0]  final_status;

  assign crc_base = (reply_count == POS_SYNC) ? 8'h00 : rx_crc;
  assign crc_next = crc8_byte(crc_base, item.rx_byte);

  // address and register echo checks; first failing one wins
  always_comb begin
    status_next = rx_status;
    priority case (reply_count)
      POS_SYNC: begin
        status_next = ST_OK;
      end
      POS_ADDR: begin
        if (rx_status == ST_OK && item.rx_byte != MASTER_ADDR) status_next = ST_BAD_ADDR;
      end
      POS_REG: begin
        if (rx_status == ST_OK && item.rx_byte != {1'b0, expected_register}) begin
          status_next = ST_BAD_REG;
        end
      end
      default: status_next = rx_status;
    endcase
  end

  // sync is compared on the eighth byte, against the sync byte in force then
  assign final_status = (rx_first != cfg.sync_byte) ? ST_BAD_SYNC :
                        (rx_status != ST_OK) ? rx_status :
                        (item.rx_byte != rx_crc) ? ST_BAD_CRC : ST_OK;

  always_comb begin
    push              = 1'b0;
    push_job.op       = JOB_WRITE;
    push_job.reg_address = item.reg_address;
    push_job.value    = item.write_value;
    push_job.status   = ST_OK;
    if (accept) begin
      priority case (item.kind)
        KIND_WRITE: begin
          push        = 1'b1;
          push_job.op = JOB_WRITE;
        end
        KIND_READ: begin
          push        = 1'b1;
          push_job.op = JOB_READ;
        end
        KIND_REPLY: begin
          push            = (reply_count == POS_WRITE_CRC);
          push_job.op     = JOB_REPLY;
          push_job.status = final_status;
          push_job.value  = (final_status == ST_OK) ? rx_data : 32'h0;
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_count       <= 3'd0;
      expected_register <= 7'd0;
    end else if (accept) begin
      if (item.kind == KIND_READ) begin
        expected_register <= item.reg_address;
        reply_count       <= 3'd0;
      end else if (item.kind == KIND_REPLY) begin
        reply_count <= reply_count + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.kind == KIND_REPLY) begin
      rx_crc    <= crc_next;
      rx_status <= status_next;
      rx_data   <= {rx_data[23:0], item.rx_byte};
      if (reply_count == POS_SYNC) rx_first <= item.rx_byte;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ucdc_queue.sv @@
// Short job queue between the front end and the byte sequencer.
`default_nettype none

module ucdc_queue
  import ucdc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output job_t      head
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_job;
  end

endmodule

`default_nettype wire

@@ hw/rtl/ucdc_back.sv @@
// Back end: serializes request datagrams with CRC and reports reply checks.
`default_nettype none

module ucdc_back
  import ucdc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic head_valid,
  input  wire job_t head,
  output logic      pop,
  input  wire logic out_stall,
  output logic      out_valid,
  output out_item_t out_item
);

  logic [2:0] byte_pos;
  logic [7:0] crc;
  logic       advance;
  logic       is_last;
  logic [7:0] cur_byte;
  logic [7:0] crc_base;
  out_item_t  result;

  assign advance  = !out_valid || !out_stall;
  assign is_last  = (head.op == JOB_WRITE) ? (byte_pos == POS_WRITE_CRC)
                                          : (byte_pos == POS_READ_CRC);
  assign crc_base = (byte_pos == POS_SYNC) ? 8'h00 : crc;

  always_comb begin
    unique case (byte_pos)
      3'd0: cur_byte = cfg.sync_byte;
      3'd1: cur_byte = cfg.node_address;
      3'd2: cur_byte = (head.op == JOB_WRITE) ? ({1'b0, head.reg_address} | WRITE_FLAG)
                                              : {1'b0, head.reg_address};
      3'd3: cur_byte = (head.op == JOB_WRITE) ? head.value[31:24] : crc;
      3'd4: cur_byte = head.value[23:16];
      3'd5: cur_byte = head.value[15:8];
      3'd6: cur_byte = head.value[7:0];
      3'd7: cur_byte = crc;
      default: cur_byte = crc;
    endcase
  end

  always_comb begin
    result = '0;
    if (head.op == JOB_REPLY) begin
      result.reply_valid  = 1'b1;
      result.reply_status = head.status;
      result.reply_data   = head.value;
    end else begin
      result.tx_valid = 1'b1;
      result.tx_byte  = cur_byte;
      result.tx_last  = is_last;
    end
  end

  assign pop = advance && head_valid && (head.op == JOB_REPLY || is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_pos  <= 3'd0;
    end else if (advance) begin
      out_valid <= head_valid;
      if (head_valid) byte_pos <= pop ? 3'd0 : byte_pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      out_item <= result;
      crc      <= crc8_byte(crc_base, cur_byte);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/uart_register_datagram_codec_unit.sv @@
// Top level of the UART register datagram codec: config registers and datapath.
//
// Input channel (in_valid/in_stall/in_item) takes three kinds of transaction:
// write commands, read requests and received reply bytes. Output channel
// (out_valid/out_stall/out_item) carries one result per transaction out.
// - Write command: 8 request bytes (sync, node, reg|0x80, value MSB first, CRC).
// - Read request: 4 request bytes (sync, node, reg, CRC); restarts reply collection.
// - Reply byte: no result until the eighth, which yields one checked status
//   and the 32-bit value (zero on any failed check).
// An accepted transaction's job passes through the job queue and then the
// output register. While out_stall is low the byte sequencer emits one
// result per cycle: one per request byte, one per completed reply.
// A 2-entry job queue lets the front end keep accepting while it works.
// in_stall is high only while the job queue is full. When the receiver
// holds out_stall, the output register holds its transaction and the
// queue fills, then the input stalls.
// Reset (rst, synchronous): node address 0, sync byte 0x05, reply count and
// expected register cleared, queue and output emptied. No clearing pass.
// Config writes (cfg_we/cfg_index/cfg_data) take effect at once; write only
// while the block is idle.
`default_nettype none

module uart_register_datagram_codec_unit
  import ucdc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_item,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  cfg_t cfg;
  logic accept;
  logic push;
  job_t push_job;
  logic pop;
  logic full;
  logic head_valid;
  job_t head;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_address <= 8'h00;
      cfg.sync_byte    <= SYNC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_ADDRESS: cfg.node_address <= cfg_data;
        CFG_SYNC_BYTE:    cfg.sync_byte    <= cfg_data;
        default:          cfg.sync_byte    <= cfg.sync_byte;
      endcase
    end
  end

  // stall depends only on queue occupancy, never on in_valid
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  ucdc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .item     (in_item),
    .push     (push),
    .push_job (push_job)
  );

  ucdc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  ucdc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire
